/* rtl/pwmt_pkg.sv */
// Shared types, codes and constants of the PWM timer channel.
package pwmt_pkg;

  localparam int unsigned CounterWidthDef = 16;
  localparam int unsigned RegWidth        = 16;
  localparam int unsigned DutyWidth       = 12;
  localparam int unsigned CfgIdxWidth     = 3;

  // Pulse widths are divided by 20 with a reciprocal multiply: 52429 / 2^20.
  localparam logic [RegWidth-1:0] DutyRecip = 16'd52429;
  localparam int unsigned         DutyShift = 20;

  localparam logic [RegWidth-1:0] AutoReloadRst = 16'd65535;
  localparam logic [RegWidth-1:0] PulseMinRst   = 16'd1000;
  localparam logic [RegWidth-1:0] PulseMaxRst   = 16'd2000;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_FORCE = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PRESCALER   = 3'd0,
    REG_AUTO_RELOAD = 3'd1,
    REG_PRELOAD_EN  = 3'd2,
    REG_OUTPUT_EN   = 3'd3,
    REG_COUNTER_EN  = 3'd4,
    REG_PULSE_MIN   = 3'd5,
    REG_PULSE_MAX   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [RegWidth-1:0] min_us;
    logic [RegWidth-1:0] max_us;
  } pulse_limits_t;

endpackage

/* rtl/pwmt_if.sv */
// Valid/ready channel interfaces for items, results and register writes.
interface pwmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] pulse_us;

  modport source (output valid, output mode, output pulse_us, input ready);
  modport sink   (input valid, input mode, input pulse_us, output ready);
endinterface

interface pwmt_out_if;
  logic        valid;
  logic        ready;
  logic        pwm_level;
  logic [15:0] count_value;
  logic        update_event;
  logic [15:0] compare_value;
  logic [11:0] duty_counts;

  modport source (output valid, output pwm_level, output count_value, output update_event,
                  output compare_value, output duty_counts, input ready);
  modport sink   (input valid, input pwm_level, input count_value, input update_event,
                  input compare_value, input duty_counts, output ready);
endinterface

interface pwmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/pwm_timer_channel.sv */
// Top level of the PWM timer channel: counters, compare registers and result register.
//
// Usage: each word on the input channel is one item: a clock tick, a pulse
// width request in microseconds, or a forced update. Every item returns
// exactly one result word with the pin level, the main count, the update
// flag, the active compare value and the last duty in counts.
// The result is valid in the cycle after acceptance. Throughput is
// one item per cycle while the receiver takes every result, set by the
// single register stage that holds the counters and the result; the pulse
// conversion is one 16 by 16 multiply in the same stage.
// When the receiver stalls, the result register holds its word and the
// input channel takes a new item only in a cycle in which that word is
// taken, so no result is lost.
// The configuration channel is always ready; registers should be written
// only while no result is pending.
// Reset clears both counters and both compare values, restores the
// register defaults and empties the result register.
module pwm_timer_channel #(
  parameter int unsigned COUNTER_WIDTH = pwmt_pkg::CounterWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pwmt_cfg_if.sink          cfg_i,
  pwmt_in_if.sink           in_i,
  pwmt_out_if.source        out_o
);
  import pwmt_pkg::*;

  logic [RegWidth-1:0] prescaler_q, auto_reload_q, pulse_min_q, pulse_max_q;
  logic                preload_en_q, output_en_q, counter_en_q;

  logic [RegWidth-1:0]      prescale_q, prescale_d;
  logic [COUNTER_WIDTH-1:0] main_q, main_d;
  logic [RegWidth-1:0]      cmp_active_q, cmp_active_d;
  logic [RegWidth-1:0]      cmp_pending_q, cmp_pending_d;
  logic [DutyWidth-1:0]     duty_q, duty_d;
  logic                     upd_d;

  logic                     out_valid_q;
  logic                     pwm_q, upd_q;
  logic [RegWidth-1:0]      count_out_q, cmp_out_q;
  logic [DutyWidth-1:0]     duty_out_q;

  logic                     in_fire;
  logic [DutyWidth-1:0]     duty_conv;
  pulse_limits_t            limits;
  mode_e                    mode;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q   <= '0;
      auto_reload_q <= AutoReloadRst;
      preload_en_q  <= 1'b0;
      output_en_q   <= 1'b0;
      counter_en_q  <= 1'b0;
      pulse_min_q   <= PulseMinRst;
      pulse_max_q   <= PulseMaxRst;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_PRESCALER:   prescaler_q   <= cfg_i.data;
        REG_AUTO_RELOAD: auto_reload_q <= cfg_i.data;
        REG_PRELOAD_EN:  preload_en_q  <= cfg_i.data[0];
        REG_OUTPUT_EN:   output_en_q   <= cfg_i.data[0];
        REG_COUNTER_EN:  counter_en_q  <= cfg_i.data[0];
        REG_PULSE_MIN:   pulse_min_q   <= cfg_i.data;
        REG_PULSE_MAX:   pulse_max_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign limits.min_us = pulse_min_q;
  assign limits.max_us = pulse_max_q;

  pwmt_duty_conv u_duty_conv (
    .pulse_us_i (in_i.pulse_us),
    .limits_i   (limits),
    .duty_o     (duty_conv)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign mode       = mode_e'(in_i.mode);

  always_comb begin
    prescale_d    = prescale_q;
    main_d        = main_q;
    cmp_active_d  = cmp_active_q;
    cmp_pending_d = cmp_pending_q;
    duty_d        = duty_q;
    upd_d         = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (counter_en_q) begin
          if (prescale_q < prescaler_q) begin
            prescale_d = prescale_q + 1'b1;
          end else begin
            prescale_d = '0;
            if (main_q < COUNTER_WIDTH'(auto_reload_q)) begin
              main_d = main_q + 1'b1;
            end else begin
              main_d       = '0;
              cmp_active_d = cmp_pending_q;
              upd_d        = 1'b1;
            end
          end
        end
      end
      MODE_PULSE: begin
        duty_d        = duty_conv;
        cmp_pending_d = RegWidth'(duty_conv);
        if (!preload_en_q) begin
          cmp_active_d = RegWidth'(duty_conv);
        end
      end
      MODE_FORCE: begin
        prescale_d   = '0;
        main_d       = '0;
        cmp_active_d = cmp_pending_q;
        upd_d        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q    <= '0;
      main_q        <= '0;
      cmp_active_q  <= '0;
      cmp_pending_q <= '0;
      duty_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        prescale_q    <= prescale_d;
        main_q        <= main_d;
        cmp_active_q  <= cmp_active_d;
        cmp_pending_q <= cmp_pending_d;
        duty_q        <= duty_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pwm_q       <= output_en_q && (main_d < COUNTER_WIDTH'(cmp_active_d));
      count_out_q <= main_d[RegWidth-1:0];
      upd_q       <= upd_d;
      cmp_out_q   <= cmp_active_d;
      duty_out_q  <= duty_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pwm_level     = pwm_q;
  assign out_o.count_value   = count_out_q;
  assign out_o.update_event  = upd_q;
  assign out_o.compare_value = cmp_out_q;
  assign out_o.duty_counts   = duty_out_q;

  a_upd_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && upd_q) |-> (count_out_q == '0))
    else $error("update event with nonzero count");

  a_force_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.mode == MODE_FORCE)) |=> (out_valid_q && upd_q && (main_q == '0)))
    else $error("forced update did not clear the counter");

  a_pwm_below_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pwm_q) |-> (count_out_q < cmp_out_q))
    else $error("pwm high at or above compare value");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (duty_out_q <= DutyWidth'(3276)))
    else $error("duty count out of range");

  a_disabled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.mode == MODE_TICK) && !counter_en_q) |=> (main_q == $past(main_q)))
    else $error("disabled counter advanced");

endmodule

/* rtl/pwmt_duty_conv.sv */
// Clamps a pulse width request and converts it from microseconds to counts.
module pwmt_duty_conv (
  input  logic [pwmt_pkg::RegWidth-1:0]  pulse_us_i,
  input  pwmt_pkg::pulse_limits_t        limits_i,
  output logic [pwmt_pkg::DutyWidth-1:0] duty_o
);
  import pwmt_pkg::*;

  localparam int unsigned ProdWidth = 2 * RegWidth;

  logic [RegWidth-1:0]  raised;
  logic [RegWidth-1:0]  clamped;
  logic [ProdWidth-1:0] prod;

  // The maximum is applied last, so it wins when the limits cross.
  always_comb begin
    raised  = (pulse_us_i < limits_i.min_us) ? limits_i.min_us : pulse_us_i;
    clamped = (raised > limits_i.max_us) ? limits_i.max_us : raised;
    prod    = ProdWidth'(clamped) * ProdWidth'(DutyRecip);
    duty_o  = prod[DutyShift +: DutyWidth];
  end

endmodule
